// ----- design/piqt_pkg.sv -----
// ----------------------------------------------------------------------------
// Point-in-quad test package
// Register indexes and widths of the configuration port. These are shared by
// the block and by anything that programs it.
// ----------------------------------------------------------------------------
package piqt_pkg;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 3;

    // Number of quad vertices.
    localparam int NUM_VTX = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX0_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX0_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX1_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX1_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX2_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX2_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX3_X = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_VERTEX3_Y = 3'd7;

endpackage

// ----- design/point_in_quad_test_top.sv -----
// ----------------------------------------------------------------------------
// Point-in-quad test
// Tests query points against a quadrilateral held in configuration registers:
// crossing-number test over the ordered corners, plus a bounding-box test.
// ----------------------------------------------------------------------------
// The block takes one query point per cycle and never raises o_busy. Each item
// gives one result. The result is strobed on o_result_valid for one cycle; the
// receiver cannot stall it. Each item passes four registers: the point capture,
// the offsets, the products and the result register, which also holds the
// intercept compare. Corner ordering and the box bounds are registered from the
// vertex registers, and the edge deltas are registered from the registered
// corner ring. Each is ready before the stage that uses it, so an item accepted
// in the cycle after a vertex write already sees the new quad. Write the
// vertices only while no item is in flight.
module point_in_quad_test_top #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [piqt_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [COORD_WIDTH-1:0]         i_cfg_data,
    // Query items.
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic signed [COORD_WIDTH-1:0]  i_point_x,
    input  logic signed [COORD_WIDTH-1:0]  i_point_y,
    // Results.
    output logic                           o_result_valid,
    output logic                           o_inside_quad,
    output logic                           o_inside_box
);

    import piqt_pkg::*;

    localparam int DIFF_W = COORD_WIDTH + 1;
    localparam int PROD_W = 2 * DIFF_W;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
    } t_vtx;

    // Corner selection, each by a fixed sequence of strict compares.
    function automatic t_vtx corner_ul(input t_vtx v0, input t_vtx v1,
                                       input t_vtx v2, input t_vtx v3);
        t_vtx a, b, t;
        a = v0;
        b = v1;
        if (b.x < a.x) begin t = a; a = b; b = t; end
        if (v2.x < b.x) begin
            b = v2;
            if (b.x < a.x) begin t = a; a = b; b = t; end
        end
        if (v3.x < b.x) b = v3;
        if (b.y < a.y) a = b;
        return a;
    endfunction

    function automatic t_vtx corner_ur(input t_vtx v0, input t_vtx v1,
                                       input t_vtx v2, input t_vtx v3);
        t_vtx a, b, t;
        a = v0;
        b = v1;
        if (b.y < a.y) begin t = a; a = b; b = t; end
        if (v2.y < b.y) begin
            b = v2;
            if (b.y < a.y) begin t = a; a = b; b = t; end
        end
        if (v3.y < b.y) b = v3;
        if (b.x > a.x) a = b;
        return a;
    endfunction

    function automatic t_vtx corner_lr(input t_vtx v0, input t_vtx v1,
                                       input t_vtx v2, input t_vtx v3);
        t_vtx a, b, t;
        a = v0;
        b = v1;
        if (b.x > a.x) begin t = a; a = b; b = t; end
        if (v2.x > b.x) b = v2;
        if (b.x > a.x) begin t = a; a = b; b = t; end
        if (v3.x > b.x) b = v3;
        if (b.y > a.y) a = b;
        return a;
    endfunction

    function automatic t_vtx corner_ll(input t_vtx v0, input t_vtx v1,
                                       input t_vtx v2, input t_vtx v3);
        t_vtx a, b, t;
        a = v0;
        b = v1;
        if (b.y > a.y) begin t = a; a = b; b = t; end
        if (v2.y > b.y) b = v2;
        if (b.y > a.y) begin t = a; a = b; b = t; end
        if (v3.y > b.y) b = v3;
        if (b.x < a.x) a = b;
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_vtx r_vtx [NUM_VTX];
    logic w_cfg_we;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_we    = i_cfg_valid && o_cfg_ready;

    // Vertex registers are written one coordinate at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_VTX; k++) begin
                r_vtx[k] <= '0;
            end
        end else if (w_cfg_we) begin
            case (i_cfg_index)
                REG_VERTEX0_X: r_vtx[0].x <= i_cfg_data;
                REG_VERTEX0_Y: r_vtx[0].y <= i_cfg_data;
                REG_VERTEX1_X: r_vtx[1].x <= i_cfg_data;
                REG_VERTEX1_Y: r_vtx[1].y <= i_cfg_data;
                REG_VERTEX2_X: r_vtx[2].x <= i_cfg_data;
                REG_VERTEX2_Y: r_vtx[2].y <= i_cfg_data;
                REG_VERTEX3_X: r_vtx[3].x <= i_cfg_data;
                REG_VERTEX3_Y: r_vtx[3].y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Quad geometry derived from the vertex registers
    // ------------------------------------------------------------------
    t_vtx                     n_ring [NUM_VTX];
    t_vtx                     r_ring [NUM_VTX];
    logic signed [DIFF_W-1:0] r_edx  [NUM_VTX];
    logic signed [DIFF_W-1:0] r_edy  [NUM_VTX];
    logic signed [COORD_WIDTH-1:0] n_min_x, n_max_x, n_min_y, n_max_y;
    logic signed [COORD_WIDTH-1:0] r_min_x, r_max_x, r_min_y, r_max_y;

    // Ordered ring: upper-left, upper-right, lower-right, lower-left.
    always_comb begin
        n_ring[0] = corner_ul(r_vtx[0], r_vtx[1], r_vtx[2], r_vtx[3]);
        n_ring[1] = corner_ur(r_vtx[0], r_vtx[1], r_vtx[2], r_vtx[3]);
        n_ring[2] = corner_lr(r_vtx[0], r_vtx[1], r_vtx[2], r_vtx[3]);
        n_ring[3] = corner_ll(r_vtx[0], r_vtx[1], r_vtx[2], r_vtx[3]);
    end

    // Bounding box over the four vertices.
    always_comb begin
        n_min_x = r_vtx[0].x;
        n_max_x = r_vtx[0].x;
        n_min_y = r_vtx[0].y;
        n_max_y = r_vtx[0].y;
        for (int k = 1; k < NUM_VTX; k++) begin
            if (r_vtx[k].x < n_min_x) n_min_x = r_vtx[k].x;
            if (r_vtx[k].x > n_max_x) n_max_x = r_vtx[k].x;
            if (r_vtx[k].y < n_min_y) n_min_y = r_vtx[k].y;
            if (r_vtx[k].y > n_max_y) n_max_y = r_vtx[k].y;
        end
    end

    // Ring and bounds are registered; edge deltas are registered from the ring.
    // Edge k runs from corner k to the previous corner.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_VTX; k++) begin
                r_ring[k] <= '0;
                r_edx[k]  <= '0;
                r_edy[k]  <= '0;
            end
            r_min_x <= '0;
            r_max_x <= '0;
            r_min_y <= '0;
            r_max_y <= '0;
        end else begin
            for (int k = 0; k < NUM_VTX; k++) begin
                r_ring[k] <= n_ring[k];
                r_edx[k]  <= DIFF_W'(r_ring[(k + NUM_VTX - 1) % NUM_VTX].x)
                             - DIFF_W'(r_ring[k].x);
                r_edy[k]  <= DIFF_W'(r_ring[(k + NUM_VTX - 1) % NUM_VTX].y)
                             - DIFF_W'(r_ring[k].y);
            end
            r_min_x <= n_min_x;
            r_max_x <= n_max_x;
            r_min_y <= n_min_y;
            r_max_y <= n_max_y;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: capture the query point
    // ------------------------------------------------------------------
    logic                          w_accept;
    logic                          r1_valid;
    logic signed [COORD_WIDTH-1:0] r1_px, r1_py;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_px <= i_point_x;
        r1_py <= i_point_y;
    end

    // ------------------------------------------------------------------
    // Stage 2: offsets from each corner, crossing and box flags
    // ------------------------------------------------------------------
    logic                     r2_valid;
    logic signed [DIFF_W-1:0] r2_oy [NUM_VTX];
    logic signed [DIFF_W-1:0] r2_ox [NUM_VTX];
    logic [NUM_VTX-1:0]       r2_cross, r2_up;
    logic                     r2_box;
    logic [NUM_VTX-1:0]       w_below;

    // A corner is below the point's row when its y is strictly less.
    always_comb begin
        for (int k = 0; k < NUM_VTX; k++) begin
            w_below[k] = r_ring[k].y < r1_py;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    // An edge straddles the row when exactly one end is below it; then the
    // edge rises (dy > 0) exactly when its own corner is the lower end.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_VTX; k++) begin
            r2_oy[k]    <= DIFF_W'(r1_py) - DIFF_W'(r_ring[k].y);
            r2_ox[k]    <= DIFF_W'(r1_px) - DIFF_W'(r_ring[k].x);
            r2_cross[k] <= w_below[k] ^ w_below[(k + NUM_VTX - 1) % NUM_VTX];
            r2_up[k]    <= w_below[k];
        end
        r2_box <= (r1_px >= r_min_x) && (r1_px <= r_max_x)
               && (r1_py >= r_min_y) && (r1_py <= r_max_y);
    end

    // ------------------------------------------------------------------
    // Stage 3: cross products, one pair of multipliers per edge
    // ------------------------------------------------------------------
    logic                     r3_valid;
    logic signed [PROD_W-1:0] r3_p1 [NUM_VTX];
    logic signed [PROD_W-1:0] r3_p2 [NUM_VTX];
    logic [NUM_VTX-1:0]       r3_cross, r3_up;
    logic                     r3_box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NUM_VTX; k++) begin
            r3_p1[k] <= r2_oy[k] * r_edx[k];
            r3_p2[k] <= r2_ox[k] * r_edy[k];
        end
        r3_cross <= r2_cross;
        r3_up    <= r2_up;
        r3_box   <= r2_box;
    end

    // ------------------------------------------------------------------
    // Stage 4: intercept compare, crossing parity and result register
    // ------------------------------------------------------------------
    logic [NUM_VTX-1:0] w_hit;
    logic               r_result_valid, r_inside_quad, r_inside_box;

    // The intercept lies left of the point when oy*dx < ox*dy for a rising
    // edge; the sense flips for a falling one.
    always_comb begin
        for (int k = 0; k < NUM_VTX; k++) begin
            w_hit[k] = r3_cross[k] && (r3_up[k] ? (r3_p1[k] < r3_p2[k])
                                                : (r3_p2[k] < r3_p1[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_inside_quad <= ^w_hit;
        r_inside_box  <= r3_box;
    end

    assign o_result_valid = r_result_valid;
    assign o_inside_quad  = r_inside_quad;
    assign o_inside_box   = r_inside_box;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every accepted item yields its result after the point capture, offset, product and result registers.
    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_result_valid)
        else $error("accepted item produced no result");

    // No result appears without a matching accepted item.
    a_no_spurious_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(w_accept, 4))
        else $error("result without a matching item");

    // Once the vertices have settled, the box bounds are well ordered.
    a_box_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!$past(w_cfg_we) && !$past(w_cfg_we, 2) && $past(i_rst_n, 2))
        |-> (r_min_x <= r_max_x) && (r_min_y <= r_max_y))
        else $error("bounding box bounds out of order");

endmodule
